[sv/day_number_to_calendar_parts_unit_macros.svh]
// ---------------------------------------------------------------------------
// Day number to calendar parts: assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ---------------------------------------------------------------------------
`ifndef DAY_NUMBER_TO_CALENDAR_PARTS_UNIT_MACROS_SVH
`define DAY_NUMBER_TO_CALENDAR_PARTS_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DNCP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DNCP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/dncp_pkg.sv]
// ---------------------------------------------------------------------------
// Day number to calendar parts: package
// Widths, cycle lengths, reciprocal constants and tables for the converter.
// ---------------------------------------------------------------------------
package dncp_pkg;

   localparam int unsigned STAGES = 10;
   localparam int unsigned REQ_W  = 24;
   localparam int unsigned RSP_W  = 56;

   localparam logic [21:0] DAYS_MAX = 22'd3652058;

   // Gregorian cycle lengths in days.
   localparam logic [17:0] D400      = 18'd146097;
   localparam logic [17:0] D400_LAST = 18'd146096;
   localparam logic [15:0] D100      = 16'd36524;
   localparam logic [10:0] D4        = 11'd1461;
   localparam logic [10:0] D4_LAST   = 11'd1460;
   localparam logic [8:0]  D1        = 9'd365;

   // Floor reciprocals; the estimate is the true quotient or one below it.
   localparam int unsigned K400  = 32;
   localparam logic [14:0] M400  = 15'((64'd1 << K400) / 64'd146097);
   localparam int unsigned K7    = 24;
   localparam logic [21:0] M7    = 22'((64'd1 << K7) / 64'd7);
   localparam int unsigned K1461 = 24;
   localparam logic [13:0] M1461 = 14'((64'd1 << K1461) / 64'd1461);

   // Exact division by seven for values below 372.
   localparam logic [8:0]  WEEK_MUL   = 9'd293;
   localparam int unsigned WEEK_SHIFT = 11;

   localparam logic [8:0] MONTH_START [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   typedef enum logic [1:0] {
      WEEK_PREV,
      WEEK_CUR,
      WEEK_NEXT
   } week_kind_type;

endpackage

[sv/day_number_to_calendar_parts_unit.sv]
// An accepted request passes through stages A to J to its result on the rsp side.
// Throughput: one request per cycle; every stage has its own valid bit and
// a stall at rsp_tready holds each full stage that has no empty stage after it.
// The depth is set by the three reciprocal multiplies, their corrections and
// the month and week selection, one step per register stage.
// Reset (synchronous, active high) empties every stage at once.
// ---------------------------------------------------------------------------
// Day number to calendar parts
// Converts a day number from 0001-01-01 into year, month, day, day of year,
// ISO week year, ISO week and weekday in a ten-stage pipeline.
// ---------------------------------------------------------------------------
`include "day_number_to_calendar_parts_unit_macros.svh"

module day_number_to_calendar_parts_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [21:0] day_number, [23:22] zero
   input  logic [dncp_pkg::REQ_W-1:0]      req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [13:0] year, [17:14] month, [22:18] day, [31:23] ordinal,
   // [45:32] iso_year, [51:46] week, [54:52] weekday, [55] zero
   output logic [dncp_pkg::RSP_W-1:0]      rsp_tdata,
   // [0] valid_res
   output logic                            rsp_tuser
);

   localparam int unsigned LAST = dncp_pkg::STAGES - 1;

   logic [dncp_pkg::STAGES-1:0] v_ff;
   logic [dncp_pkg::STAGES-1:0] v_in;
   logic [dncp_pkg::STAGES-1:0] adv;

   // Stage A
   logic [21:0] a_dn_in;
   logic        a_ok_in;
   logic [36:0] a_p400_in;
   logic [43:0] a_p7_in;
   logic [21:0] a_dn_ff;
   logic        a_ok_ff;
   logic [36:0] a_p400_ff;
   logic [43:0] a_p7_ff;
   // Stage B
   logic [4:0]  b_q400_in;
   logic [18:0] b_r400_in;
   logic [3:0]  b_r7_in;
   logic [19:0] b_q7;
   logic [21:0] b_diff400;
   logic [21:0] b_diff7;
   logic        b_ok_ff;
   logic [4:0]  b_q400_ff;
   logic [18:0] b_r400_ff;
   logic [3:0]  b_r7_ff;
   // Stage C
   logic [13:0] c_year_in;
   logic [17:0] c_days_in;
   logic [2:0]  c_wd_in;
   logic [4:0]  c_q400;
   logic        c_ok_ff;
   logic [13:0] c_year_ff;
   logic [17:0] c_days_ff;
   logic [2:0]  c_wd_ff;
   // Stage D
   logic [1:0]  d_q100;
   logic [13:0] d_year_in;
   logic [15:0] d_days_in;
   logic        d_ok_ff;
   logic [13:0] d_year_ff;
   logic [15:0] d_days_ff;
   logic [2:0]  d_wd_ff;
   logic        d_c3_ff;
   logic        d_c0_ff;
   // Stage E
   logic [29:0] e_p_in;
   logic        e_ok_ff;
   logic [13:0] e_year_ff;
   logic [15:0] e_days_ff;
   logic [2:0]  e_wd_ff;
   logic        e_c3_ff;
   logic        e_c0_ff;
   logic [29:0] e_p_ff;
   // Stage F
   logic [4:0]  f_q4_in;
   logic [15:0] f_diff;
   logic        f_ok_ff;
   logic [13:0] f_year_ff;
   logic [11:0] f_r4_ff;
   logic [4:0]  f_q4_ff;
   logic [2:0]  f_wd_ff;
   logic        f_c3_ff;
   logic        f_c0_ff;
   // Stage G
   logic [4:0]  g_q4;
   logic [10:0] g_days_in;
   logic [13:0] g_year_in;
   logic        g_ok_ff;
   logic [13:0] g_year_ff;
   logic [10:0] g_days_ff;
   logic [2:0]  g_wd_ff;
   logic        g_c3_ff;
   logic        g_c0_ff;
   logic        g_y24_ff;
   logic        g_y0_ff;
   // Stage H
   logic [1:0]  h_q1;
   logic [8:0]  h_ord_in;
   logic        h_ok_ff;
   logic [13:0] h_year_ff;
   logic [8:0]  h_ord_ff;
   logic [2:0]  h_wd_ff;
   logic        h_leap_ff;
   logic        h_leapp_ff;
   // Stage I
   logic [3:0]                    i_month_in;
   logic [8:0]                    i_adj_in;
   logic [8:0]                    i_start_in;
   dncp_pkg::week_kind_type       i_kind_in;
   logic [5:0]                    i_wprev_in;
   logic [13:0]                   i_wyear_in;
   logic [9:0]                    i_thu_sum;
   logic [3:0]                    i_dec_raw;
   logic [2:0]                    i_dec31;
   logic                          i_ok_ff;
   logic [13:0]                   i_year_ff;
   logic [8:0]                    i_ord_ff;
   logic [2:0]                    i_wd_ff;
   logic [3:0]                    i_month_ff;
   logic [8:0]                    i_adj_ff;
   logic [8:0]                    i_start_ff;
   dncp_pkg::week_kind_type       i_kind_ff;
   logic [5:0]                    i_wprev_ff;
   logic [8:0]                    i_thu_ff;
   logic [13:0]                   i_wyear_ff;
   // Stage J (output register)
   logic [17:0] j_wprod;
   logic [5:0]  j_week_in;
   logic        j_ok_ff;
   logic [13:0] j_year_ff;
   logic [3:0]  j_month_ff;
   logic [4:0]  j_day_ff;
   logic [8:0]  j_ord_ff;
   logic [13:0] j_wyear_ff;
   logic [5:0]  j_week_ff;
   logic [2:0]  j_wd_ff;

   // Handshake: a stage moves when it is empty or the next one moves.
   always_comb begin
      adv[LAST] = !v_ff[LAST] || rsp_tready;
      for (int k = LAST - 1; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k + 1];
      end
      v_in = {v_ff[LAST-1:0], req_tvalid};
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = v_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k <= LAST; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   // Stage A: range check and reciprocal products.
   always_comb begin
      a_dn_in   = req_tdata[21:0];
      a_ok_in   = a_dn_in <= dncp_pkg::DAYS_MAX;
      a_p400_in = 37'(a_dn_in) * 37'(dncp_pkg::M400);
      a_p7_in   = 44'(a_dn_in) * 44'(dncp_pkg::M7);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         a_dn_ff   <= a_dn_in;
         a_ok_ff   <= a_ok_in;
         a_p400_ff <= a_p400_in;
         a_p7_ff   <= a_p7_in;
      end
   end

   // Stage B: quotient estimates and raw remainders.
   always_comb begin
      b_q400_in = a_p400_ff[36:32];
      b_diff400 = a_dn_ff - 22'(22'(b_q400_in) * 22'(dncp_pkg::D400));
      b_r400_in = b_diff400[18:0];
      b_q7      = a_p7_ff[43:24];
      b_diff7   = a_dn_ff - 22'(22'(b_q7) * 22'd7);
      b_r7_in   = b_diff7[3:0];
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         b_ok_ff   <= a_ok_ff;
         b_q400_ff <= b_q400_in;
         b_r400_ff <= b_r400_in;
         b_r7_ff   <= b_r7_in;
      end
   end

   // Stage C: correct the estimates; start the year from the 400-year count.
   always_comb begin
      if (b_r400_ff >= 19'(dncp_pkg::D400)) begin
         c_q400    = b_q400_ff + 5'd1;
         c_days_in = 18'(b_r400_ff - 19'(dncp_pkg::D400));
      end else begin
         c_q400    = b_q400_ff;
         c_days_in = b_r400_ff[17:0];
      end
      c_year_in = 14'd1 + 14'(14'(c_q400) * 14'd400);
      c_wd_in   = (b_r7_ff >= 4'd7) ? 3'(b_r7_ff - 4'd7) : b_r7_ff[2:0];
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         c_ok_ff   <= b_ok_ff;
         c_year_ff <= c_year_in;
         c_days_ff <= c_days_in;
         c_wd_ff   <= c_wd_in;
      end
   end

   // Stage D: century within the 400-year cycle.
   always_comb begin
      if (c_days_ff == dncp_pkg::D400_LAST) begin
         // The last day of the 400-year cycle closes the fourth century.
         d_q100    = 2'd3;
         d_days_in = dncp_pkg::D100;
      end else begin
         priority if (c_days_ff >= 18'(3 * dncp_pkg::D100)) begin
            d_q100 = 2'd3;
         end else if (c_days_ff >= 18'(2 * dncp_pkg::D100)) begin
            d_q100 = 2'd2;
         end else if (c_days_ff >= 18'(dncp_pkg::D100)) begin
            d_q100 = 2'd1;
         end else begin
            d_q100 = 2'd0;
         end
         d_days_in = 16'(c_days_ff - 18'(18'(d_q100) * 18'(dncp_pkg::D100)));
      end
      d_year_in = c_year_ff + 14'(14'(d_q100) * 14'd100);
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         d_ok_ff   <= c_ok_ff;
         d_year_ff <= d_year_in;
         d_days_ff <= d_days_in;
         d_wd_ff   <= c_wd_ff;
         d_c3_ff   <= d_q100 == 2'd3;
         d_c0_ff   <= d_q100 == 2'd0;
      end
   end

   // Stage E: reciprocal product for the 4-year cycle.
   assign e_p_in = 30'(d_days_ff) * 30'(dncp_pkg::M1461);

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         e_ok_ff   <= d_ok_ff;
         e_year_ff <= d_year_ff;
         e_days_ff <= d_days_ff;
         e_wd_ff   <= d_wd_ff;
         e_c3_ff   <= d_c3_ff;
         e_c0_ff   <= d_c0_ff;
         e_p_ff    <= e_p_in;
      end
   end

   // Stage F: 4-year estimate and raw remainder.
   always_comb begin
      f_q4_in = e_p_ff[28:24];
      f_diff  = e_days_ff - 16'(16'(f_q4_in) * 16'(dncp_pkg::D4));
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         f_ok_ff   <= e_ok_ff;
         f_year_ff <= e_year_ff;
         f_r4_ff   <= f_diff[11:0];
         f_q4_ff   <= f_q4_in;
         f_wd_ff   <= e_wd_ff;
         f_c3_ff   <= e_c3_ff;
         f_c0_ff   <= e_c0_ff;
      end
   end

   // Stage G: correct the 4-year count.
   always_comb begin
      if (f_r4_ff >= 12'(dncp_pkg::D4)) begin
         g_q4      = f_q4_ff + 5'd1;
         g_days_in = 11'(f_r4_ff - 12'(dncp_pkg::D4));
      end else begin
         g_q4      = f_q4_ff;
         g_days_in = f_r4_ff[10:0];
      end
      g_year_in = f_year_ff + 14'({g_q4, 2'b00});
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         g_ok_ff   <= f_ok_ff;
         g_year_ff <= g_year_in;
         g_days_ff <= g_days_in;
         g_wd_ff   <= f_wd_ff;
         g_c3_ff   <= f_c3_ff;
         g_c0_ff   <= f_c0_ff;
         g_y24_ff  <= g_q4 == 5'd24;
         g_y0_ff   <= g_q4 == 5'd0;
      end
   end

   // Stage H: year within the 4-year cycle and the leap flags.
   always_comb begin
      if (g_days_ff == dncp_pkg::D4_LAST) begin
         // The last day of a 4-year cycle is day 365 of its leap year.
         h_q1     = 2'd3;
         h_ord_in = dncp_pkg::D1;
      end else begin
         priority if (g_days_ff >= 11'(3 * dncp_pkg::D1)) begin
            h_q1 = 2'd3;
         end else if (g_days_ff >= 11'(2 * dncp_pkg::D1)) begin
            h_q1 = 2'd2;
         end else if (g_days_ff >= 11'(dncp_pkg::D1)) begin
            h_q1 = 2'd1;
         end else begin
            h_q1 = 2'd0;
         end
         h_ord_in = 9'(g_days_ff - 11'(11'(h_q1) * 11'(dncp_pkg::D1)));
      end
   end

   // A year is leap when it is the fourth of its 4-year cycle, unless it
   // closes a century other than the fourth. The year before is leap when
   // this one opens a 4-year cycle, with the same exception one step back.
   always_ff @(posedge clock) begin
      if (adv[7]) begin
         h_ok_ff    <= g_ok_ff;
         h_year_ff  <= g_year_ff + 14'(h_q1);
         h_ord_ff   <= h_ord_in;
         h_wd_ff    <= g_wd_ff;
         h_leap_ff  <= (h_q1 == 2'd3) && (!g_y24_ff || g_c3_ff);
         h_leapp_ff <= (h_q1 == 2'd0) && (!g_y0_ff || g_c0_ff);
      end
   end

   // Stage I: month selection and ISO week classification.
   always_comb begin
      i_start_in = '0;
      i_adj_in   = h_ord_ff;
      priority if (h_ord_ff < dncp_pkg::MONTH_START[1]) begin
         i_month_in = 4'd0;
      end else if (h_ord_ff < dncp_pkg::MONTH_START[2]
                   || (h_leap_ff && h_ord_ff == dncp_pkg::MONTH_START[2])) begin
         i_month_in = 4'd1;
         i_start_in = dncp_pkg::MONTH_START[1];
      end else begin
         i_adj_in   = h_ord_ff - 9'(h_leap_ff);
         i_month_in = 4'd2;
         i_start_in = dncp_pkg::MONTH_START[2];
         for (int m = 3; m < 12; m++) begin
            if (i_adj_in >= dncp_pkg::MONTH_START[m]) begin
               i_month_in = 4'(m);
               i_start_in = dncp_pkg::MONTH_START[m];
            end
         end
      end

      // Thursday of this week, as a day of year.
      i_thu_sum = 10'(h_ord_ff) + 10'd3 - 10'(h_wd_ff);
      // Weekday of the previous December 31; the ordinal is at most 2 here.
      i_dec_raw = 4'(h_wd_ff) + 4'd6 - 4'(h_ord_ff[1:0]);
      i_dec31   = (i_dec_raw >= 4'd7) ? 3'(i_dec_raw - 4'd7) : i_dec_raw[2:0];
      i_wprev_in = (i_dec31 == 3'd3 || (i_dec31 == 3'd4 && h_leapp_ff)) ? 6'd52 : 6'd51;

      priority if (10'(h_ord_ff) + 10'd3 < 10'(h_wd_ff)) begin
         i_kind_in  = dncp_pkg::WEEK_PREV;
         i_wyear_in = h_year_ff - 14'd1;
      end else if (i_thu_sum >= 10'(dncp_pkg::D1) + 10'(h_leap_ff)) begin
         i_kind_in  = dncp_pkg::WEEK_NEXT;
         i_wyear_in = h_year_ff + 14'd1;
      end else begin
         i_kind_in  = dncp_pkg::WEEK_CUR;
         i_wyear_in = h_year_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         i_ok_ff    <= h_ok_ff;
         i_year_ff  <= h_year_ff;
         i_ord_ff   <= h_ord_ff;
         i_wd_ff    <= h_wd_ff;
         i_month_ff <= i_month_in;
         i_adj_ff   <= i_adj_in;
         i_start_ff <= i_start_in;
         i_kind_ff  <= i_kind_in;
         i_wprev_ff <= i_wprev_in;
         i_thu_ff   <= i_thu_sum[8:0];
         i_wyear_ff <= i_wyear_in;
      end
   end

   // Stage J: day of month, week number, and zeroing of out-of-range items.
   always_comb begin
      j_wprod = 18'(i_thu_ff) * 18'(dncp_pkg::WEEK_MUL);
      unique case (i_kind_ff)
         dncp_pkg::WEEK_PREV: j_week_in = i_wprev_ff;
         dncp_pkg::WEEK_CUR:  j_week_in = 6'(j_wprod >> dncp_pkg::WEEK_SHIFT);
         dncp_pkg::WEEK_NEXT: j_week_in = 6'd0;
         default:             j_week_in = 6'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[9]) begin
         j_ok_ff <= i_ok_ff;
         if (i_ok_ff) begin
            j_year_ff  <= i_year_ff;
            j_month_ff <= i_month_ff;
            j_day_ff   <= 5'(i_adj_ff - i_start_ff);
            j_ord_ff   <= i_ord_ff;
            j_wyear_ff <= i_wyear_ff;
            j_week_ff  <= j_week_in;
            j_wd_ff    <= i_wd_ff;
         end else begin
            j_year_ff  <= '0;
            j_month_ff <= '0;
            j_day_ff   <= '0;
            j_ord_ff   <= '0;
            j_wyear_ff <= '0;
            j_week_ff  <= '0;
            j_wd_ff    <= '0;
         end
      end
   end

   assign rsp_tuser = j_ok_ff;
   assign rsp_tdata = {1'b0, j_wd_ff, j_week_ff, j_wyear_ff, j_ord_ff,
                       j_day_ff, j_month_ff, j_year_ff};

   `DNCP_ASSERT_SAME(a_invalid_zero, rsp_tvalid && !rsp_tuser, rsp_tdata == '0,
                     "out-of-range request produced nonzero fields")
   `DNCP_ASSERT_SAME(a_field_range, rsp_tvalid && rsp_tuser,
                     j_month_ff <= 4'd11 && j_day_ff <= 5'd30 && j_wd_ff <= 3'd6,
                     "month, day or weekday out of range")
   `DNCP_ASSERT_SAME(a_last_day, rsp_tvalid && rsp_tuser && j_ord_ff == 9'd365,
                     j_month_ff == 4'd11 && j_day_ff == 5'd30,
                     "day 365 of a year is not December 31")
   `DNCP_ASSERT_SAME(a_week53, rsp_tvalid && rsp_tuser && j_week_ff == 6'd52,
                     j_wyear_ff == j_year_ff || j_wyear_ff == j_year_ff - 14'd1,
                     "week 53 reported in the following week year")
   `DNCP_ASSERT_NEXT(a_range_flag,
                     req_tvalid && req_tready && req_tdata[21:0] <= dncp_pkg::DAYS_MAX,
                     v_ff[0] && a_ok_ff,
                     "in-range request not flagged valid in the first stage")

endmodule

[test/day_number_to_calendar_parts_unit_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Day number to calendar parts: result checker
// Watches both stream channels, works out the calendar parts of every
// accepted day number and compares each returned response with the oldest
// outstanding one, field by field.
// ---------------------------------------------------------------------------
module day_number_to_calendar_parts_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [dncp_pkg::REQ_W-1:0] req_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [dncp_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                       rsp_tuser,
   output int unsigned                mismatches,
   output int unsigned                pending,
   output int unsigned                dates_checked,
   output int unsigned                out_of_range_seen
);

   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      logic        valid_res;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [8:0]  ordinal;
      logic [13:0] iso_year;
      logic [5:0]  week;
      logic [2:0]  weekday;
   } calendar_parts_type;

   calendar_parts_type expected_parts [$];
   calendar_parts_type wanted;
   calendar_parts_type returned;

   function automatic bit leap_year_of(input int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
   endfunction

   // First day of each month in a common year, zero based.
   function automatic int unsigned month_first_day(input int unsigned m);
      case (m)
         0:       return 0;
         1:       return 31;
         2:       return 59;
         3:       return 90;
         4:       return 120;
         5:       return 151;
         6:       return 181;
         7:       return 212;
         8:       return 243;
         9:       return 273;
         10:      return 304;
         default: return 334;
      endcase
   endfunction

   function automatic string parts_text(input calendar_parts_type p);
      return $sformatf("valid %0d %0d-%0d-%0d ord %0d wk %0d/%0d wd %0d", p.valid_res,
         p.year, p.month, p.day, p.ordinal, p.iso_year, p.week, p.weekday);
   endfunction

   function automatic calendar_parts_type calendar_parts_of(input logic [21:0] dn);
      calendar_parts_type parts;
      int unsigned yr, rem, ord, mon, dom, wd, wyr, wk, leap, adj, dec31;
      int thursday;
      parts = '0;
      if (dn > dncp_pkg::DAYS_MAX) begin
         return parts;
      end
      yr  = 1 + 400 * (dn / 146097);
      rem = dn % 146097;
      // The last day of a 400-year cycle is day 365 of its final leap year.
      if (rem == 146096) begin
         yr += 300;
         rem = 36524;
      end else begin
         yr += 100 * (rem / 36524);
         rem = rem % 36524;
      end
      yr += 4 * (rem / 1461);
      rem = rem % 1461;
      if (rem == 1460) begin
         yr += 3;
         rem = 365;
      end else begin
         yr += rem / 365;
         rem = rem % 365;
      end
      ord  = rem;
      leap = leap_year_of(yr);

      if (ord < 31) begin
         mon = 0;
         dom = ord;
      end else if (ord < 59 || (leap == 1 && ord == 59)) begin
         mon = 1;
         dom = ord - 31;
      end else begin
         adj = ord - leap;
         mon = 2;
         for (int m = 3; m < 12; m++) begin
            if (adj >= month_first_day(m)) begin
               mon = m;
            end
         end
         dom = adj - month_first_day(mon);
      end

      // The ISO week belongs to the year that holds its Thursday.
      wd = dn % 7;
      thursday = int'(ord) + 3 - int'(wd);
      if (thursday < 0) begin
         dec31 = (wd + 7 - ord - 1) % 7;
         wyr = yr - 1;
         wk = (dec31 == 3 || (dec31 == 4 && leap_year_of(wyr))) ? 52 : 51;
      end else if (thursday >= 365 + int'(leap)) begin
         wyr = yr + 1;
         wk = 0;
      end else begin
         wyr = yr;
         wk = thursday / 7;
      end

      parts.valid_res = 1'b1;
      parts.year      = yr[13:0];
      parts.month     = mon[3:0];
      parts.day       = dom[4:0];
      parts.ordinal   = ord[8:0];
      parts.iso_year  = wyr[13:0];
      parts.week      = wk[5:0];
      parts.weekday   = wd[2:0];
      return parts;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         mismatches        = 0;
         pending           = 0;
         dates_checked     = 0;
         out_of_range_seen = 0;
         expected_parts.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            returned.valid_res = rsp_tuser;
            returned.year      = rsp_tdata[13:0];
            returned.month     = rsp_tdata[17:14];
            returned.day       = rsp_tdata[22:18];
            returned.ordinal   = rsp_tdata[31:23];
            returned.iso_year  = rsp_tdata[45:32];
            returned.week      = rsp_tdata[51:46];
            returned.weekday   = rsp_tdata[54:52];
            if (expected_parts.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: response with no request outstanding, tdata %h tuser %b",
                     $realtime, rsp_tdata, rsp_tuser);
               end
            end else begin
               wanted = expected_parts.pop_front();
               dates_checked++;
               if (!wanted.valid_res) begin
                  out_of_range_seen++;
               end
               if (returned.valid_res !== wanted.valid_res
                     || returned.year !== wanted.year
                     || returned.month !== wanted.month
                     || returned.day !== wanted.day
                     || returned.ordinal !== wanted.ordinal
                     || returned.iso_year !== wanted.iso_year
                     || returned.week !== wanted.week
                     || returned.weekday !== wanted.weekday
                     || rsp_tdata[55] !== 1'b0) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t: mismatch, expected %s", $realtime, parts_text(wanted));
                     $display("%0t:           got %s pad %b", $realtime,
                        parts_text(returned), rsp_tdata[55]);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_parts.push_back(calendar_parts_of(req_tdata[21:0]));
         end
         pending = expected_parts.size();
      end
   end

endmodule

[test/day_number_to_calendar_parts_unit_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Day number to calendar parts: testbench top
// Drives day numbers into the converter under changing sender gaps and
// receiver stalls; the checker beside it predicts and compares every response.
// ---------------------------------------------------------------------------
module day_number_to_calendar_parts_unit_tb;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned PHASE_REQUESTS = 200;

   logic                       clock;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [dncp_pkg::REQ_W-1:0] req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [dncp_pkg::RSP_W-1:0] rsp_tdata;
   logic                       rsp_tuser;

   int unsigned mismatches, pending, dates_checked, out_of_range_seen;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned idle_cycles   = 0;

   day_number_to_calendar_parts_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   day_number_to_calendar_parts_checker checker_unit (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .mismatches        (mismatches),
      .pending           (pending),
      .dates_checked     (dates_checked),
      .out_of_range_seen (out_of_range_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Ends the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a transfer.", idle_cycles);
         $display("day_number_to_calendar_parts_unit regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_day(input logic [21:0] dn);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, dn};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Holds the sender off until every outstanding request has come back.
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      do begin
         @(negedge clock);
      end while (pending != 0);
   endtask

   // Mostly in-range dates, a share of them near year and cycle boundaries,
   // plus the top of the range and numbers past it.
   function automatic logic [21:0] random_day();
      int unsigned pick, base;
      pick = $urandom_range(99);
      if (pick < 55) begin
         return 22'($urandom_range(dncp_pkg::DAYS_MAX));
      end else if (pick < 78) begin
         base = 146097 * $urandom_range(24) + 36524 * $urandom_range(3)
              + 1461 * $urandom_range(24) + 365 * $urandom_range(3);
         if (base >= 6) begin
            base = base + $urandom_range(12) - 6;
         end
         return 22'(base);
      end else if (pick < 88) begin
         return 22'(dncp_pkg::DAYS_MAX - $urandom_range(400) + $urandom_range(20));
      end else begin
         return 22'($urandom_range(dncp_pkg::DAYS_MAX + 1, 22'h3FFFFF));
      end
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 28;
      recv_idle_pct = 61;

      send_day(22'd0);          // 0001-01-01, a Monday
      send_day(22'd1);
      send_day(22'd58);         // February 28 of a common year
      send_day(22'd59);         // March 1 of a common year
      send_day(22'd1154);       // February 29, 0004
      send_day(22'd1460);       // last day of a 4-year cycle
      send_day(22'd1461);
      send_day(22'd36524);      // 0101-01-01, first day of the second century
      send_day(22'd146095);
      send_day(22'd146096);     // last day of a 400-year cycle
      send_day(22'd146097);
      send_day(22'd732311);     // Sunday after a common-year Saturday: week 52 of 2005
      send_day(22'd731946);     // Saturday after a leap-year Friday: week 53 of 2004
      send_day(22'd733772);     // Friday after a Thursday: week 53 of 2009
      send_day(22'd733404);     // late December in week 1 of the next ISO year
      send_day(22'd3652052);
      send_day(dncp_pkg::DAYS_MAX);  // 9999-12-31
      send_day(22'd3652059);         // first number past the calendar
      send_day(22'h2AAAAA);
      send_day(22'h155555);
      send_day(22'h3FFFFF);

      wait_until_drained();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 28;
               recv_idle_pct = 61;
            end
            1: begin
               send_idle_pct = 61;
               recv_idle_pct = 28;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            send_day(random_day());
         end
         wait_until_drained();
      end

      repeat (2 * dncp_pkg::STAGES) @(negedge clock);

      $display("Converted %0d requests: %0d calendar dates and %0d numbers past 9999-12-31,",
         dates_checked, dates_checked - out_of_range_seen, out_of_range_seen);
      $display("with cycle ends, ISO week rollovers and three sender/receiver stall mixes.");
      if (mismatches == 0 && pending == 0) begin
         $display("day_number_to_calendar_parts_unit regression: pass");
      end else begin
         $display("day_number_to_calendar_parts_unit regression: fail");
      end
      $finish;
   end

endmodule
